>>> rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cvsd_pkg.sv
// types and constants of the can vehicle status decoder
`timescale 1ns / 1ps
package cvsd_pkg;

  localparam int ID_W     = 11;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_ID  = 3'd4;

  // identifiers after reset
  localparam logic [ID_W-1:0] RST_SPEED_ID = 11'h412;
  localparam logic [ID_W-1:0] RST_STEER_ID = 11'h236;
  localparam logic [ID_W-1:0] RST_BRAKE_ID = 11'h231;
  localparam logic [ID_W-1:0] RST_BODY_ID  = 11'h424;
  localparam logic [ID_W-1:0] RST_GEAR_ID  = 11'h418;

  localparam logic [17:0] HEADING_BIAS = 18'd4096;

  // brake byte codes
  localparam logic [7:0] BRAKE_OFF = 8'h00;
  localparam logic [7:0] BRAKE_ON  = 8'h02;
  // door byte codes
  localparam logic [7:0] DOOR_SHUT_A = 8'h0F;
  localparam logic [7:0] DOOR_SHUT_B = 8'h0D;
  localparam logic [7:0] DOOR_OPEN   = 8'h0C;
  // blinker byte codes
  localparam logic [7:0] BLINK_LEFT  = 8'h02;
  localparam logic [7:0] BLINK_RIGHT = 8'h01;
  localparam logic [7:0] BLINK_BOTH  = 8'h03;
  // light and belt byte codes
  localparam logic [7:0] LOW_ON      = 8'h47;
  localparam logic [7:0] LOW_OFF_A   = 8'h43;
  localparam logic [7:0] LOW_OFF_B   = 8'h03;
  localparam logic [7:0] HIGH_ON_A   = 8'h24;
  localparam logic [7:0] HIGH_ON_B   = 8'h64;
  localparam logic [7:0] HIGH_OFF    = 8'h00;
  localparam logic [7:0] BELT_ON     = 8'h03;
  localparam logic [7:0] BELT_OFF    = 8'h43;
  // gear selector letters
  localparam logic [7:0] GEAR_CHR_P = 8'h50;
  localparam logic [7:0] GEAR_CHR_R = 8'h52;
  localparam logic [7:0] GEAR_CHR_N = 8'h4E;
  localparam logic [7:0] GEAR_CHR_D = 8'h44;

  // gear codes
  localparam logic [2:0] GEAR_UNKNOWN = 3'd0;
  localparam logic [2:0] GEAR_PARK    = 3'd1;
  localparam logic [2:0] GEAR_REVERSE = 3'd2;
  localparam logic [2:0] GEAR_NEUTRAL = 3'd3;
  localparam logic [2:0] GEAR_DRIVE   = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte_0;
    logic [7:0]      byte_1;
    logic [7:0]      byte_2;
    logic [7:0]      byte_3;
    logic [7:0]      byte_4;
  } in_t;

  typedef struct packed {
    logic [31:0]        frame_count;
    logic [31:0]        speed_index;
    logic [7:0]         speed;
    logic signed [15:0] heading;
    logic [23:0]        distance;
    logic               brake_on;
    logic               door_open;
    logic [1:0]         blinkers;
    logic               low_beam;
    logic               high_beam;
    logic               belt_fastened;
    logic [2:0]         gear;
  } out_t;

  typedef struct packed {
    logic brake;
    logic door;
    logic left;
    logic right;
    logic low;
    logic high;
    logic belt;
  } flags_t;

  typedef struct packed {
    logic [31:0] counter;
    logic [31:0] speed_index;
    logic [7:0]  speed;
    logic [15:0] heading;
    logic [23:0] distance;
    flags_t      flags;
    logic [2:0]  gear;
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] speed_id;
    logic [ID_W-1:0] steer_id;
    logic [ID_W-1:0] brake_id;
    logic [ID_W-1:0] body_id;
    logic [ID_W-1:0] gear_id;
  } ids_t;

endpackage

>>> rtl/core/can_vehicle_status_decoder.sv
// top level of the can vehicle status decoder
// a frame is registered in the input register, and its status record is then registered
// in the output register once that register is empty or being emptied
// one frame per cycle while out_stall is low, limited by the single pass through the update logic
// in_stall rises only while both registers hold a frame and the output is stalled
// reset (rst_n low, synchronous): status record cleared, identifiers to defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"
module can_vehicle_status_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // frame input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cvsd_pkg::in_t                     in_data,
  // status output
  output logic                              out_valid,
  input  logic                              out_stall,
  output cvsd_pkg::out_t                    out_data,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [cvsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cvsd_pkg::ID_W-1:0]         cfg_wdata
);
  import cvsd_pkg::*;

  // input register stage
  logic    s1_valid_r, s1_valid_nxt;
  in_t     s1_data_r;
  // output register stage
  logic    out_valid_r, out_valid_nxt;
  out_t    out_data_r;
  // held status record and identifiers
  status_t status_r, status_nxt;
  ids_t    ids_r, ids_nxt;
  out_t    result;

  logic    in_take;
  logic    s1_adv;

  // the input stage moves on when the output register is empty or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & out_stall);

  // decode of the frame in the input register against the held record
  cvsd_update u_update (
    .frame  (s1_data_r),
    .ids    (ids_r),
    .cur    (status_r),
    .nxt    (status_nxt),
    .result (result)
  );

  // configuration writes: the user must make them only while idle; the block itself does not enforce this
  always_comb begin
    ids_nxt = ids_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_ID: ids_nxt.speed_id = cfg_wdata;
        CFG_STEER_ID: ids_nxt.steer_id = cfg_wdata;
        CFG_BRAKE_ID: ids_nxt.brake_id = cfg_wdata;
        CFG_BODY_ID:  ids_nxt.body_id  = cfg_wdata;
        CFG_GEAR_ID:  ids_nxt.gear_id  = cfg_wdata;
        default:      ids_nxt = ids_r;
      endcase
    end
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= '0;
      ids_r       <= '{speed_id: RST_SPEED_ID, steer_id: RST_STEER_ID,
                       brake_id: RST_BRAKE_ID, body_id: RST_BODY_ID,
                       gear_id: RST_GEAR_ID};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ids_r       <= ids_nxt;
      // the record steps once per transaction that reaches the output register
      if (s1_adv) begin
        status_r <= status_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a frame leaving the input stage always lands in the output register
  `ASSERT_CLK(a_adv_fills_out, clk, rst_n, s1_adv |=> out_valid_r, "advance lost a result")
  // shown count is one past the counter the frame saw
  `ASSERT_CLK(a_count_step, clk, rst_n,
    s1_adv |=> (out_data_r.frame_count == ($past(status_r.counter) + 32'd1)),
    "frame count mismatch")
  // backpressure only while the input register holds a frame
  `ASSERT_ALWAYS(a_stall_needs_full, clk, in_stall |-> s1_valid_r, "stall with empty input stage")

endmodule

>>> rtl/core/cvsd_update.sv
// frame decode and status record update, purely combinational
`timescale 1ns / 1ps
module cvsd_update (
  input  cvsd_pkg::in_t     frame,
  input  cvsd_pkg::ids_t    ids,
  input  cvsd_pkg::status_t cur,
  output cvsd_pkg::status_t nxt,
  output cvsd_pkg::out_t    result
);
  import cvsd_pkg::*;

  logic [31:0] cnt_inc;
  logic [17:0] raw;
  logic [17:0] adj;
  flags_t      f;

  assign cnt_inc = cur.counter + 32'd1;
  // signed raw angle, then halve rounding toward zero
  assign raw = {2'b00, frame.byte_0, frame.byte_1} - HEADING_BIAS;
  assign adj = raw + {17'd0, raw[17]};

  always_comb begin
    nxt = cur;
    f   = cur.flags;
    nxt.counter = cnt_inc;

    if (frame.frame_id == ids.speed_id) begin
      nxt.speed       = frame.byte_1;
      nxt.speed_index = cnt_inc;
      nxt.counter     = cur.counter + 32'd2;
      nxt.distance    = {frame.byte_2, frame.byte_3, frame.byte_4};
    end
    if (frame.frame_id == ids.steer_id) begin
      nxt.heading = adj[16:1];
    end
    if (frame.frame_id == ids.brake_id) begin
      if (frame.byte_4 == BRAKE_OFF) f.brake = 1'b0;
      if (frame.byte_4 == BRAKE_ON)  f.brake = 1'b1;
    end
    if (frame.frame_id == ids.body_id) begin
      if (frame.byte_2 == DOOR_SHUT_A || frame.byte_2 == DOOR_SHUT_B) f.door = 1'b0;
      if (frame.byte_2 == DOOR_OPEN) f.door = 1'b1;
      if (frame.byte_1 == BLINK_LEFT) begin
        f.left = 1'b1;
      end else if (frame.byte_1 == BLINK_RIGHT) begin
        f.right = 1'b1;
      end else if (frame.byte_1 == BLINK_BOTH) begin
        f.left  = 1'b1;
        f.right = 1'b1;
      end else begin
        f.left  = 1'b0;
        f.right = 1'b0;
      end
      if (frame.byte_0 == LOW_ON) f.low = 1'b1;
      if (frame.byte_1 == HIGH_ON_A || frame.byte_1 == HIGH_ON_B) f.high = 1'b1;
      if (frame.byte_0 == LOW_OFF_A || frame.byte_0 == LOW_OFF_B) f.low = 1'b0;
      if (frame.byte_1 == HIGH_OFF) f.high = 1'b0;
      if (frame.byte_0 == BELT_ON)  f.belt = 1'b1;
      if (frame.byte_0 == BELT_OFF) f.belt = 1'b0;
    end
    nxt.flags = f;
    if (frame.frame_id == ids.gear_id) begin
      case (frame.byte_0)
        GEAR_CHR_P: nxt.gear = GEAR_PARK;
        GEAR_CHR_R: nxt.gear = GEAR_REVERSE;
        GEAR_CHR_N: nxt.gear = GEAR_NEUTRAL;
        GEAR_CHR_D: nxt.gear = GEAR_DRIVE;
        default:    nxt.gear = GEAR_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    result.frame_count   = cnt_inc;
    result.speed_index   = nxt.speed_index;
    result.speed         = nxt.speed;
    result.heading       = $signed(nxt.heading);
    result.distance      = nxt.distance;
    result.brake_on      = nxt.flags.brake;
    result.door_open     = nxt.flags.door;
    result.blinkers      = {nxt.flags.left, nxt.flags.right};
    result.low_beam      = nxt.flags.low;
    result.high_beam     = nxt.flags.high;
    result.belt_fastened = nxt.flags.belt;
    result.gear          = nxt.gear;
  end

endmodule

>>> bench/testbench.sv
// self-checking bench for the can vehicle status decoder: random frames and id settings
`timescale 1ns / 1ps
module testbench;
  import cvsd_pkg::*;

  // cycles with no transaction on either channel before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // tail after the final drain in which a late extra record would still be checked
  localparam int TAIL_CYCLES = 6;

  // byte values that hit the decode cases of every frame kind, plus all ones
  localparam logic [7:0] CODE_BYTES [16] = '{
    BRAKE_OFF, BRAKE_ON, BLINK_RIGHT, BLINK_BOTH, DOOR_OPEN, DOOR_SHUT_B,
    DOOR_SHUT_A, HIGH_ON_A, HIGH_ON_B, LOW_OFF_A, LOW_ON, GEAR_CHR_P,
    GEAR_CHR_R, GEAR_CHR_N, GEAR_CHR_D, 8'hFF
  };

  // holds its own copy of the status record and the frame ids, and the
  // queue of records the decoder still owes
  class status_tracker;
    ids_t               ids;
    logic [31:0]        frame_counter;
    logic [31:0]        speed_mark;
    logic [7:0]         held_speed;
    logic signed [15:0] held_heading;
    logic [23:0]        held_distance;
    flags_t             flags;
    logic [2:0]         held_gear;
    out_t               expected_records[$];
    int                 errors;

    function new();
      ids = '{RST_SPEED_ID, RST_STEER_ID, RST_BRAKE_ID, RST_BODY_ID, RST_GEAR_ID};
      frame_counter = '0;
      speed_mark    = '0;
      held_speed    = '0;
      held_heading  = '0;
      held_distance = '0;
      flags         = '0;
      held_gear     = GEAR_UNKNOWN;
      errors        = 0;
    endfunction

    function void set_id(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
      case (idx)
        CFG_SPEED_ID: ids.speed_id = val;
        CFG_STEER_ID: ids.steer_id = val;
        CFG_BRAKE_ID: ids.brake_id = val;
        CFG_BODY_ID:  ids.body_id  = val;
        CFG_GEAR_ID:  ids.gear_id  = val;
        default: ;
      endcase
    endfunction

    // one accepted frame: update the held record and queue the record it shows
    function void note_frame(in_t f);
      int   raw;
      out_t rec;
      frame_counter = frame_counter + 1;
      rec.frame_count = frame_counter;
      if (f.frame_id == ids.speed_id) begin
        held_speed    = f.byte_1;
        speed_mark    = frame_counter;
        frame_counter = frame_counter + 1;
        held_distance = {f.byte_2, f.byte_3, f.byte_4};
      end
      if (f.frame_id == ids.steer_id) begin
        raw = int'({f.byte_0, f.byte_1}) - 4096;
        held_heading = 16'(raw / 2);
      end
      if (f.frame_id == ids.brake_id) begin
        if (f.byte_4 == BRAKE_OFF) flags.brake = 1'b0;
        if (f.byte_4 == BRAKE_ON)  flags.brake = 1'b1;
      end
      if (f.frame_id == ids.body_id) begin
        if (f.byte_2 == DOOR_SHUT_A || f.byte_2 == DOOR_SHUT_B) flags.door = 1'b0;
        if (f.byte_2 == DOOR_OPEN) flags.door = 1'b1;
        if (f.byte_1 == BLINK_LEFT) flags.left = 1'b1;
        else if (f.byte_1 == BLINK_RIGHT) flags.right = 1'b1;
        else if (f.byte_1 == BLINK_BOTH) begin
          flags.left  = 1'b1;
          flags.right = 1'b1;
        end else begin
          flags.left  = 1'b0;
          flags.right = 1'b0;
        end
        if (f.byte_0 == LOW_ON) flags.low = 1'b1;
        if (f.byte_1 == HIGH_ON_A || f.byte_1 == HIGH_ON_B) flags.high = 1'b1;
        if (f.byte_0 == LOW_OFF_A || f.byte_0 == LOW_OFF_B) flags.low = 1'b0;
        if (f.byte_1 == HIGH_OFF) flags.high = 1'b0;
        if (f.byte_0 == BELT_ON) flags.belt = 1'b1;
        if (f.byte_0 == BELT_OFF) flags.belt = 1'b0;
      end
      if (f.frame_id == ids.gear_id) begin
        case (f.byte_0)
          GEAR_CHR_P: held_gear = GEAR_PARK;
          GEAR_CHR_R: held_gear = GEAR_REVERSE;
          GEAR_CHR_N: held_gear = GEAR_NEUTRAL;
          GEAR_CHR_D: held_gear = GEAR_DRIVE;
          default:    held_gear = GEAR_UNKNOWN;
        endcase
      end
      rec.speed_index   = speed_mark;
      rec.speed         = held_speed;
      rec.heading       = held_heading;
      rec.distance      = held_distance;
      rec.brake_on      = flags.brake;
      rec.door_open     = flags.door;
      rec.blinkers      = {flags.left, flags.right};
      rec.low_beam      = flags.low;
      rec.high_beam     = flags.high;
      rec.belt_fastened = flags.belt;
      rec.gear          = held_gear;
      expected_records.push_back(rec);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_record(out_t got);
      out_t want;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected status record, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("frame_count", want.frame_count, got.frame_count);
      compare_field("speed_index", want.speed_index, got.speed_index);
      compare_field("speed", 32'(want.speed), 32'(got.speed));
      compare_field("heading", 32'(want.heading), 32'(got.heading));
      compare_field("distance", 32'(want.distance), 32'(got.distance));
      compare_field("brake_on", 32'(want.brake_on), 32'(got.brake_on));
      compare_field("door_open", 32'(want.door_open), 32'(got.door_open));
      compare_field("blinkers", 32'(want.blinkers), 32'(got.blinkers));
      compare_field("low_beam", 32'(want.low_beam), 32'(got.low_beam));
      compare_field("high_beam", 32'(want.high_beam), 32'(got.high_beam));
      compare_field("belt_fastened", 32'(want.belt_fastened), 32'(got.belt_fastened));
      compare_field("gear", 32'(want.gear), 32'(got.gear));
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SPEED_ID;
  logic [ID_W-1:0]      cfg_wdata = '0;

  // when set, neither side idles: the long back-to-back stretch
  logic                 calm      = 1'b0;
  int                   idle_cycles = 0;

  status_tracker tracker = new();

  can_vehicle_status_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver side stalls about a third of the cycles unless in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  // both channels sampled at the edge with pre-edge values; a frame is noted
  // before any record is checked so the queue order never races
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_frame(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_record(out_data);
  end

  // hang detection: no transaction on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_t build_frame(logic [ID_W-1:0] id, logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
    in_t f;
    f.frame_id = id;
    f.byte_0   = b0;
    f.byte_1   = b1;
    f.byte_2   = b2;
    f.byte_3   = b3;
    f.byte_4   = b4;
    return f;
  endfunction

  // half the bytes land on a decode code, the rest are anything
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 1) return CODE_BYTES[4'($urandom_range(0, 15))];
    return 8'($urandom_range(0, 255));
  endfunction

  // most frames carry one of the programmed ids, the rest any id at all
  function automatic in_t random_frame();
    logic [ID_W-1:0] id;
    case ($urandom_range(0, 7))
      0:       id = tracker.ids.speed_id;
      1:       id = tracker.ids.steer_id;
      2:       id = tracker.ids.brake_id;
      3:       id = tracker.ids.body_id;
      4:       id = tracker.ids.gear_id;
      default: id = ID_W'($urandom_range(0, 2047));
    endcase
    return build_frame(id, pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endfunction

  // offer one frame, after idle cycles drawn one at a time, and hold it until taken
  task automatic send_frame(input in_t f);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
  endtask

  // every frame yields a record, so once the queue is empty the decoder is idle;
  // the queue is looked at on the falling edge, after the monitor has run
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    tracker.set_id(idx, val);
    @(posedge clk);
  endtask

  // new id set, written only while nothing is in flight
  task automatic load_ids(input ids_t v);
    drain();
    write_reg(CFG_SPEED_ID, v.speed_id);
    write_reg(CFG_STEER_ID, v.steer_id);
    write_reg(CFG_BRAKE_ID, v.brake_id);
    write_reg(CFG_BODY_ID, v.body_id);
    write_reg(CFG_GEAR_ID, v.gear_id);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_frame(random_frame());
  endtask

  initial begin
    ids_t            v;
    logic [ID_W-1:0] shared;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // speed frame at both byte extremes
    send_frame(build_frame(RST_SPEED_ID, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(build_frame(RST_SPEED_ID, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // heading: most negative, most positive, and truncation toward zero both sides
    send_frame(build_frame(RST_STEER_ID, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_STEER_ID, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_STEER_ID, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_STEER_ID, 8'h0F, 8'hFD, 8'h00, 8'h00, 8'h00));
    // brake on, unknown code keeps it, then off
    send_frame(build_frame(RST_BRAKE_ID, 8'h00, 8'h00, 8'h00, 8'h00, BRAKE_ON));
    send_frame(build_frame(RST_BRAKE_ID, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05));
    send_frame(build_frame(RST_BRAKE_ID, 8'h00, 8'h00, 8'h00, 8'h00, BRAKE_OFF));
    // body: left then right keeps left, codes that clear, both, belt and beams
    send_frame(build_frame(RST_BODY_ID, LOW_ON, BLINK_LEFT, DOOR_OPEN, 8'h00, 8'h00));
    send_frame(build_frame(RST_BODY_ID, BELT_ON, BLINK_RIGHT, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_BODY_ID, 8'h00, HIGH_ON_A, DOOR_SHUT_B, 8'h00, 8'h00));
    send_frame(build_frame(RST_BODY_ID, LOW_ON, BLINK_BOTH, DOOR_OPEN, 8'h00, 8'h00));
    send_frame(build_frame(RST_BODY_ID, BELT_OFF, HIGH_ON_B, DOOR_SHUT_A, 8'h00, 8'h00));
    send_frame(build_frame(RST_BODY_ID, 8'hFF, HIGH_OFF, 8'hFF, 8'hFF, 8'hFF));
    // every gear letter and an unknown one
    send_frame(build_frame(RST_GEAR_ID, GEAR_CHR_P, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_GEAR_ID, GEAR_CHR_R, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_GEAR_ID, GEAR_CHR_N, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_GEAR_ID, GEAR_CHR_D, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(build_frame(RST_GEAR_ID, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    // ids that match nothing only count
    send_frame(build_frame(11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(build_frame(11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    run_random(300);

    // lowest and highest ids everywhere: all five updates hit one frame
    load_ids('{11'h000, 11'h000, 11'h000, 11'h000, 11'h000});
    run_random(200);
    load_ids('{11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF});
    run_random(200);

    // one random id shared by all registers
    shared = ID_W'($urandom_range(0, 2047));
    load_ids('{shared, shared, shared, shared, shared});
    run_random(250);

    // random ids, back to back with no idling on either side
    v = '{ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
          ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
          ID_W'($urandom_range(0, 2047))};
    load_ids(v);
    calm = 1'b1;
    run_random(300);
    drain();
    calm = 1'b0;

    v = '{ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
          ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
          ID_W'($urandom_range(0, 2047))};
    load_ids(v);
    run_random(250);

    load_ids('{RST_SPEED_ID, RST_STEER_ID, RST_BRAKE_ID, RST_BODY_ID, RST_GEAR_ID});
    run_random(200);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
